@@ sv/olist_pkg.sv @@
// Shared types and codes for the ordered list engine.
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;

   typedef enum logic [2:0] {
      OP_CLEAR    = 3'd0,
      OP_DUMP     = 3'd1,
      OP_INS_HEAD = 3'd2,
      OP_INS_TAIL = 3'd3,
      OP_INS_POS  = 3'd4,
      OP_REM_HEAD = 3'd5,
      OP_REM_TAIL = 3'd6,
      OP_REM_POS  = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_BADPOS = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DUMP,
      ST_INS,
      ST_DEL
   } state_type;

endpackage

`default_nettype wire

@@ sv/olist_channels.sv @@
// Command and result channel interfaces of the ordered list engine.
`timescale 1ns / 1ps
`default_nettype none

interface olist_req_if import olist_pkg::*;;
   logic                        valid;
   logic                        ready;
   opcode_type                  opcode;
   logic signed [VALUE_W-1:0]   value_in;
   logic        [POS_W-1:0]     position;

   modport source (output valid, output opcode, output value_in, output position,
                   input ready);
   modport sink   (input valid, input opcode, input value_in, input position,
                   output ready);
endinterface

interface olist_rsp_if import olist_pkg::*;;
   logic                        valid;
   logic                        ready;
   status_type                  status;
   logic signed [VALUE_W-1:0]   value_out;
   logic        [POS_W-1:0]     rank;
   logic        [POS_W-1:0]     length;
   logic                        last;

   modport source (output valid, output status, output value_out, output rank,
                   output length, output last, input ready);
   modport sink   (input valid, input status, input value_out, input rank,
                   input length, input last, output ready);
endinterface

`default_nettype wire

@@ sv/ordered_list_engine.sv @@
// Ordered list engine: a bounded positional list kept in a synchronous memory.
//
//   channel   direction   contents
//   req_ch    in          opcode, value_in, position
//   rsp_ch    out         status, value_out, rank, length, last
//
// Commands are handled one at a time. Clear and failed commands are answered
// from idle; a tail insert moves no entries. An insert or removal at index k
// moves the entries from k to the list end, one entry per cycle through the
// memory port. A dump gives one item per cycle from a registered read port
// while results are not stalled. Reset is synchronous and empties the list at
// once; the memory is not cleared. A stalled result holds the engine in place.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_engine import olist_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   olist_req_if.sink    req_ch,
   olist_rsp_if.source  rsp_ch
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   logic signed [VALUE_W-1:0] mem [DEPTH];

   state_type                 state_ff, state_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [AW-1:0]             ptr_ff, ptr_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic                      issue_ff, issue_in;
   logic                      pend_ff, pend_in;
   logic [AW-1:0]             pend_addr_ff, pend_addr_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic signed [VALUE_W-1:0] res_ff, res_in;
   logic signed [VALUE_W-1:0] rd_data_ff;

   logic                      ov_ff, ov_in;
   status_type                o_status_ff, o_status_in;
   logic signed [VALUE_W-1:0] o_value_ff, o_value_in;
   logic [POS_W-1:0]          o_rank_ff, o_rank_in;
   logic [POS_W-1:0]          o_len_ff, o_len_in;
   logic                      o_last_ff, o_last_in;

   logic                      rd_en, wr_en;
   logic [AW-1:0]             rd_addr, wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   logic                      out_free, accept, emit;
   logic                      is_full, is_empty, pos_bad;
   logic [XW-1:0]             pos_x, cnt_x;
   logic [AW-1:0]             last_addr, pos_idx;
   logic [CW-1:0]             rank_x;

   assign out_free     = !ov_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign pos_x     = XW'(req_ch.position);
   assign cnt_x     = XW'(cnt_ff);
   assign is_full   = (cnt_ff == CW'(DEPTH));
   assign is_empty  = (cnt_ff == '0);
   assign pos_bad   = (pos_x == '0) || (pos_x > cnt_x);
   assign pos_idx   = AW'(pos_x - XW'(1));
   assign last_addr = AW'(cnt_ff - CW'(1));
   assign rank_x    = CW'(pend_addr_ff) + CW'(1);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      val_in       = val_ff;
      res_in       = res_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = val_ff;
      emit         = 1'b0;
      o_status_in  = STAT_OK;
      o_value_in   = '0;
      o_rank_in    = '0;
      o_len_in     = POS_W'(cnt_ff);
      o_last_in    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_ch.opcode)
                  OP_CLEAR: begin
                     cnt_in   = '0;
                     emit     = 1'b1;
                     o_len_in = '0;
                  end
                  OP_DUMP: begin
                     if (is_empty) begin
                        emit        = 1'b1;
                        o_status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_DUMP;
                        ptr_in   = '0;
                        issue_in = 1'b1;
                        pend_in  = 1'b0;
                     end
                  end
                  OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                     if ((req_ch.opcode == OP_INS_POS) && pos_bad) begin
                        emit        = 1'b1;
                        o_status_in = STAT_BADPOS;
                     end else if (is_full) begin
                        emit        = 1'b1;
                        o_status_in = STAT_FULL;
                     end else begin
                        unique case (req_ch.opcode)
                           OP_INS_HEAD: idx_in = '0;
                           OP_INS_TAIL: idx_in = AW'(cnt_ff);
                           default:     idx_in = pos_idx;
                        endcase
                        state_in = ST_INS;
                        val_in   = req_ch.value_in;
                        ptr_in   = last_addr;
                        issue_in = (CW'(idx_in) < cnt_ff);
                        pend_in  = 1'b0;
                     end
                  end
                  OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS: begin
                     if (is_empty) begin
                        emit        = 1'b1;
                        o_status_in = STAT_EMPTY;
                     end else if ((req_ch.opcode == OP_REM_POS) && pos_bad) begin
                        emit        = 1'b1;
                        o_status_in = STAT_BADPOS;
                     end else begin
                        unique case (req_ch.opcode)
                           OP_REM_HEAD: idx_in = '0;
                           OP_REM_TAIL: idx_in = last_addr;
                           default:     idx_in = pos_idx;
                        endcase
                        state_in = ST_DEL;
                        ptr_in   = idx_in;
                        issue_in = 1'b1;
                        pend_in  = 1'b0;
                     end
                  end
               endcase
            end
         end

         ST_DUMP: begin
            if (pend_ff && out_free) begin
               emit       = 1'b1;
               o_value_in = rd_data_ff;
               o_rank_in  = POS_W'(rank_x);
               o_last_in  = (pend_addr_ff == last_addr);
               pend_in    = 1'b0;
               if (pend_addr_ff == last_addr) begin
                  state_in = ST_IDLE;
               end
            end
            if (issue_ff && (!pend_ff || out_free)) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_ff;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               if (ptr_ff == last_addr) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + AW'(1);
               end
            end
         end

         ST_INS: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff + AW'(1);
               wr_data = rd_data_ff;
               pend_in = 1'b0;
            end
            if (issue_ff) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_ff;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               if (ptr_ff == idx_ff) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - AW'(1);
               end
            end
            if (!issue_ff && !pend_ff) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff;
               wr_data  = val_ff;
               cnt_in   = cnt_ff + CW'(1);
               emit     = 1'b1;
               o_len_in = POS_W'(cnt_in);
               state_in = ST_IDLE;
            end
         end

         ST_DEL: begin
            if (pend_ff) begin
               if (pend_addr_ff == idx_ff) begin
                  res_in = rd_data_ff;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = pend_addr_ff - AW'(1);
                  wr_data = rd_data_ff;
               end
               pend_in = 1'b0;
            end
            if (issue_ff) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_ff;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               if (ptr_ff == last_addr) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + AW'(1);
               end
            end
            if (!issue_ff && !pend_ff) begin
               cnt_in     = cnt_ff - CW'(1);
               emit       = 1'b1;
               o_value_in = res_ff;
               o_len_in   = POS_W'(cnt_in);
               state_in   = ST_IDLE;
            end
         end
      endcase

      ov_in = ov_ff && !rsp_ch.ready;
      if (emit) begin
         ov_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         issue_ff <= 1'b0;
         pend_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      val_ff       <= val_in;
      res_ff       <= res_in;
      if (emit) begin
         o_status_ff <= o_status_in;
         o_value_ff  <= o_value_in;
         o_rank_ff   <= o_rank_in;
         o_len_ff    <= o_len_in;
         o_last_ff   <= o_last_in;
      end
   end

   assign rsp_ch.valid     = ov_ff;
   assign rsp_ch.status    = o_status_ff;
   assign rsp_ch.value_out = o_value_ff;
   assign rsp_ch.rank      = o_rank_ff;
   assign rsp_ch.length    = o_len_ff;
   assign rsp_ch.last      = o_last_ff;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the ordered list engine with a queue-based list mirror.
`timescale 1ns / 1ps

module tb_top;
   import olist_pkg::*;

   localparam int DEPTH      = 16;
   localparam int IDLE_LIMIT = 5000;
   localparam int TAIL_WAIT  = 40;

   typedef struct {
      status_type                status;
      logic signed [VALUE_W-1:0] value_out;
      logic        [POS_W-1:0]   rank;
      logic        [POS_W-1:0]   length;
      logic                      last;
   } rsp_item_type;

   class list_mirror;
      logic signed [VALUE_W-1:0] cells[$];
      rsp_item_type              pending[$];
      int                        errors = 0;

      function void apply_command(opcode_type op, logic signed [VALUE_W-1:0] val,
                                  logic [POS_W-1:0] pos);
         rsp_item_type r;
         rsp_item_type d;
         int           n;
         n = cells.size();
         r.status    = STAT_OK;
         r.value_out = '0;
         r.rank      = '0;
         r.last      = 1'b1;
         case (op)
            OP_CLEAR: begin
               cells.delete();
            end
            OP_DUMP: begin
               if (n == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  for (int i = 0; i < n; i++) begin
                     d.status    = STAT_OK;
                     d.value_out = cells[i];
                     d.rank      = POS_W'(i + 1);
                     d.length    = POS_W'(n);
                     d.last      = (i == n - 1);
                     pending.push_back(d);
                  end
                  return;
               end
            end
            OP_INS_HEAD, OP_INS_TAIL: begin
               if (n >= DEPTH) begin
                  r.status = STAT_FULL;
               end else if (op == OP_INS_HEAD) begin
                  cells.push_front(val);
               end else begin
                  cells.push_back(val);
               end
            end
            OP_INS_POS: begin
               if (pos < 1 || pos > n) begin
                  r.status = STAT_BADPOS;
               end else if (n >= DEPTH) begin
                  r.status = STAT_FULL;
               end else begin
                  cells.insert(pos - 1, val);
               end
            end
            OP_REM_HEAD, OP_REM_TAIL: begin
               if (n == 0) begin
                  r.status = STAT_EMPTY;
               end else if (op == OP_REM_HEAD) begin
                  r.value_out = cells.pop_front();
               end else begin
                  r.value_out = cells.pop_back();
               end
            end
            default: begin
               if (n == 0) begin
                  r.status = STAT_EMPTY;
               end else if (pos < 1 || pos > n) begin
                  r.status = STAT_BADPOS;
               end else begin
                  r.value_out = cells[pos - 1];
                  cells.delete(pos - 1);
               end
            end
         endcase
         r.length = POS_W'(cells.size());
         pending.push_back(r);
      endfunction

      function void check_result(status_type st, logic signed [VALUE_W-1:0] val,
                                 logic [POS_W-1:0] rank, logic [POS_W-1:0] len,
                                 logic last);
         rsp_item_type e;
         if (pending.size() == 0) begin
            $error("unexpected result item: status %0d value_out %0d", st, val);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st);
            errors++;
         end
         if (val !== e.value_out) begin
            $error("value_out: expected %0d, actual %0d", e.value_out, val);
            errors++;
         end
         if (rank !== e.rank) begin
            $error("rank: expected %0d, actual %0d", e.rank, rank);
            errors++;
         end
         if (len !== e.length) begin
            $error("length: expected %0d, actual %0d", e.length, len);
            errors++;
         end
         if (last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   quiet = 1'b0;
   int   idle_cycles = 0;

   list_mirror mirror = new();

   olist_req_if req_bus ();
   olist_rsp_if rsp_bus ();

   ordered_list_engine #(.DEPTH(DEPTH)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_command(opcode_type op, logic signed [VALUE_W-1:0] val,
                               logic [POS_W-1:0] pos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= op;
      req_bus.value_in <= val;
      req_bus.position <= pos;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      mirror.apply_command(op, val, pos);
   endtask

   task automatic send_random(int mix);
      int r;
      int ins_share;
      int rem_share;
      int n;
      logic signed [VALUE_W-1:0] val;
      logic [POS_W-1:0] pos;
      opcode_type op;
      n = mirror.cells.size();
      case (mix)
         0:       begin ins_share = 75; rem_share = 12; end
         1:       begin ins_share = 25; rem_share = 62; end
         default: begin ins_share = 45; rem_share = 42; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_share) begin
         op = opcode_type'($urandom_range(OP_INS_HEAD, OP_INS_POS));
      end else if (r < ins_share + rem_share) begin
         op = opcode_type'($urandom_range(OP_REM_HEAD, OP_REM_POS));
      end else if (r < 97) begin
         op = OP_DUMP;
      end else begin
         op = OP_CLEAR;
      end
      case ($urandom_range(0, 15))
         0:       val = 32'sh8000_0000;
         1:       val = 32'sh7fff_ffff;
         2:       val = '0;
         3:       val = -32'sd1;
         default: val = $urandom;
      endcase
      if ($urandom_range(0, 5) == 0) begin
         pos = POS_W'($urandom_range(0, 31));
      end else begin
         pos = POS_W'($urandom_range(0, n + 1));
      end
      send_command(op, val, pos);
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         int stall;
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            mirror.check_result(rsp_bus.status, rsp_bus.value_out, rsp_bus.rank,
                                rsp_bus.length, rsp_bus.last);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               stall = pick_gap();
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.opcode   <= OP_CLEAR;
      req_bus.value_in <= '0;
      req_bus.position <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed commands on an empty list, the value extremes and bad positions.
      send_command(OP_DUMP,     '0, 5'd0);
      send_command(OP_REM_HEAD, '0, 5'd0);
      send_command(OP_REM_TAIL, '0, 5'd0);
      send_command(OP_REM_POS,  '0, 5'd1);
      send_command(OP_REM_POS,  '0, 5'd0);
      send_command(OP_INS_POS,  32'sd7, 5'd1);
      send_command(OP_INS_POS,  32'sd7, 5'd0);
      send_command(OP_INS_HEAD, 32'sh8000_0000, 5'd31);
      send_command(OP_INS_TAIL, 32'sh7fff_ffff, 5'd0);
      send_command(OP_INS_POS,  -32'sd1, 5'd1);
      send_command(OP_INS_POS,  32'sd0, 5'd3);
      send_command(OP_INS_POS,  32'sd5, 5'd5);
      send_command(OP_INS_POS,  32'sh5555_aaaa, 5'd31);
      send_command(OP_DUMP,     '0, 5'd0);
      send_command(OP_REM_POS,  '0, 5'd0);
      send_command(OP_REM_POS,  '0, 5'd31);
      send_command(OP_REM_POS,  '0, 5'd2);
      send_command(OP_REM_POS,  '0, 5'd3);
      send_command(OP_REM_TAIL, '0, 5'd0);
      send_command(OP_REM_HEAD, '0, 5'd0);
      send_command(OP_CLEAR,    '0, 5'd0);
      send_command(OP_DUMP,     '0, 5'd0);

      for (int phase = 0; phase < 8; phase++) begin
         quiet = (phase % 4 == 3);
         repeat (50) send_random(phase % 3);
      end
      quiet = 1'b0;

      req_bus.valid <= 1'b0;
      while (mirror.pending.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (mirror.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/olist_pkg.sv
sv/olist_channels.sv
sv/ordered_list_engine.sv
verif/tb_top.sv
